[rtl/core/mrs_pkg.sv]
// Package for the matrix row sum and saddle point search block.
// Holds the matrix sizes and the field widths; used by the interfaces and the core.
package mrs_pkg;

    localparam int ROWS        = 8;
    localparam int COLS        = 8;
    localparam int CELLS       = ROWS * COLS;
    localparam int ELEM_W      = 16;
    localparam int ROW_W       = 3;
    localparam int COL_W       = 3;
    localparam int ADDR_W      = 6;
    localparam int SUM_W       = 19;
    localparam int STEP_W      = 4;

    localparam logic [ADDR_W-1:0] LAST_CELL     = ADDR_W'(CELLS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW      = ROW_W'(ROWS - 1);
    localparam logic [STEP_W-1:0] ROW_SCAN_END  = STEP_W'(COLS);
    localparam logic [STEP_W-1:0] COL_SCAN_END  = STEP_W'(ROWS);

endpackage

[rtl/core/mrs_if.sv]
// Valid/ready channel interfaces for matrix elements in and per-row results out.
// Depends on mrs_pkg for the field widths.
interface mrs_in_if
    import mrs_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [ELEM_W-1:0] element;

    modport source (output valid, output element, input ready);
    modport sink   (input valid, input element, output ready);
endinterface

interface mrs_out_if
    import mrs_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [ROW_W-1:0]         row_index;
    logic signed [SUM_W-1:0]  row_sum;
    logic                     has_negative;
    logic signed [ELEM_W-1:0] row_minimum;
    logic [COL_W-1:0]         minimum_column;
    logic                     is_saddle;
    logic                     last_row;

    modport source (output valid, output row_index, output row_sum, output has_negative,
                    output row_minimum, output minimum_column, output is_saddle,
                    output last_row, input ready);
    modport sink   (input valid, input row_index, input row_sum, input has_negative,
                    input row_minimum, input minimum_column, input is_saddle,
                    input last_row, output ready);
endinterface

[rtl/core/matrix_row_sum_and_saddle_point.sv]
// Top level of the matrix row sum and saddle point search block.
// Depends on mrs_pkg and on the mrs_in_if and mrs_out_if channel interfaces.
//
// Usage: the elements channel takes one signed element per beat, row-major, for
// an 8 by 8 matrix; loading runs at one beat per cycle. After the final beat the
// input stalls and the block gives 8 beats on the results channel, one per row in
// row order, each with the row sum, a negative flag, the row minimum, the column
// of its first occurrence and the saddle flag; last_row marks the final row.
// Each row is worked out from the matrix memory, which has one write port for
// loading and one read port whose read data arrive in the cycle after the
// address: a row scan, then a scan of the column that holds the row minimum,
// then a move of the result into the output register. The output register
// lets the next row be worked out while a result waits; a stalled receiver
// holds the block once a second result is ready. The elements channel reopens
// as soon as the final row's result is in the output register. Reset empties
// the load count and the output register; the memory contents are not cleared
// and are always rewritten before use.
module matrix_row_sum_and_saddle_point
    import mrs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    mrs_in_if.sink    elements,
    mrs_out_if.source results
);

    typedef enum logic [1:0] {ST_LOAD, ST_ROW, ST_COL, ST_EMIT} state_t;

    state_t                   state_reg;
    logic [ADDR_W-1:0]        load_cnt_reg;
    logic [ROW_W-1:0]         row_reg;
    logic [STEP_W-1:0]        step_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic                     neg_reg;
    logic signed [ELEM_W-1:0] min_reg;
    logic [COL_W-1:0]         mcol_reg;
    logic                     saddle_reg;
    logic signed [ELEM_W-1:0] rd_data_reg;

    logic                     out_valid_reg;
    logic [ROW_W-1:0]         out_row_reg;
    logic signed [SUM_W-1:0]  out_sum_reg;
    logic                     out_neg_reg;
    logic signed [ELEM_W-1:0] out_min_reg;
    logic [COL_W-1:0]         out_mcol_reg;
    logic                     out_saddle_reg;
    logic                     out_last_reg;

    logic signed [SUM_W-1:0]  sum_next;
    logic                     neg_next;
    logic signed [ELEM_W-1:0] min_next;
    logic [COL_W-1:0]         mcol_next;
    logic                     saddle_next;

    logic signed [ELEM_W-1:0] mem [CELLS];
    logic [ADDR_W-1:0]        rd_addr;
    logic                     in_beat;
    logic                     emit_go;
    logic                     first_data;
    logic [COL_W-1:0]         data_col;
    logic signed [SUM_W-1:0]  data_ext;

    assign elements.ready = (state_reg == ST_LOAD);
    assign in_beat        = elements.valid && elements.ready;
    assign emit_go        = (state_reg == ST_EMIT) && (!out_valid_reg || results.ready);

    assign results.valid          = out_valid_reg;
    assign results.row_index      = out_row_reg;
    assign results.row_sum        = out_sum_reg;
    assign results.has_negative   = out_neg_reg;
    assign results.row_minimum    = out_min_reg;
    assign results.minimum_column = out_mcol_reg;
    assign results.is_saddle      = out_saddle_reg;
    assign results.last_row       = out_last_reg;

    always_comb
    begin
        if (state_reg == ST_COL)
        begin
            rd_addr = {step_reg[ROW_W-1:0], mcol_reg};
        end
        else
        begin
            rd_addr = {row_reg, step_reg[COL_W-1:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            mem[load_cnt_reg] <= elements.element;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // The data in rd_data_reg belong to the address issued one step earlier.
    assign first_data = (step_reg == STEP_W'(1));
    assign data_col   = COL_W'(step_reg - STEP_W'(1));
    assign data_ext   = SUM_W'(rd_data_reg);

    always_comb
    begin
        sum_next    = first_data ? data_ext : SUM_W'(sum_reg + data_ext);
        neg_next    = (first_data ? 1'b0 : neg_reg) | rd_data_reg[ELEM_W-1];
        min_next    = min_reg;
        mcol_next   = mcol_reg;
        if (first_data || (rd_data_reg < min_reg))
        begin
            min_next  = rd_data_reg;
            mcol_next = data_col;
        end
        saddle_next = (first_data ? 1'b1 : saddle_reg) & ~(min_reg < rd_data_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            load_cnt_reg   <= '0;
            row_reg        <= '0;
            step_reg       <= '0;
            sum_reg        <= '0;
            neg_reg        <= 1'b0;
            min_reg        <= '0;
            mcol_reg       <= '0;
            saddle_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_row_reg    <= '0;
            out_sum_reg    <= '0;
            out_neg_reg    <= 1'b0;
            out_min_reg    <= '0;
            out_mcol_reg   <= '0;
            out_saddle_reg <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= emit_go || (out_valid_reg && !results.ready);

            unique case (state_reg)
                ST_LOAD:
                begin
                    if (in_beat)
                    begin
                        if (load_cnt_reg == LAST_CELL)
                        begin
                            load_cnt_reg <= '0;
                            row_reg      <= '0;
                            step_reg     <= '0;
                            state_reg    <= ST_ROW;
                        end
                        else
                        begin
                            load_cnt_reg <= ADDR_W'(load_cnt_reg + ADDR_W'(1));
                        end
                    end
                end

                ST_ROW:
                begin
                    if (step_reg != '0)
                    begin
                        sum_reg  <= sum_next;
                        neg_reg  <= neg_next;
                        min_reg  <= min_next;
                        mcol_reg <= mcol_next;
                    end
                    if (step_reg == ROW_SCAN_END)
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_COL;
                    end
                    else
                    begin
                        step_reg <= STEP_W'(step_reg + STEP_W'(1));
                    end
                end

                ST_COL:
                begin
                    if (step_reg != '0)
                    begin
                        saddle_reg <= saddle_next;
                    end
                    if (step_reg == COL_SCAN_END)
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        step_reg <= STEP_W'(step_reg + STEP_W'(1));
                    end
                end

                ST_EMIT:
                begin
                    if (emit_go)
                    begin
                        out_row_reg    <= row_reg;
                        out_sum_reg    <= sum_reg;
                        out_neg_reg    <= neg_reg;
                        out_min_reg    <= min_reg;
                        out_mcol_reg   <= mcol_reg;
                        out_saddle_reg <= saddle_reg;
                        out_last_reg   <= (row_reg == LAST_ROW);
                        step_reg       <= '0;
                        if (row_reg == LAST_ROW)
                        begin
                            row_reg   <= '0;
                            state_reg <= ST_LOAD;
                        end
                        else
                        begin
                            row_reg   <= ROW_W'(row_reg + ROW_W'(1));
                            state_reg <= ST_ROW;
                        end
                    end
                end

                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    a_last_row_index: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.last_row |-> results.row_index == LAST_ROW)
        else $error("last_row set on a result that is not the final row");

    a_final_beat_closes_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && load_cnt_reg == LAST_CELL |=> !elements.ready)
        else $error("input still open after the final element of a matrix");

    a_last_row_reopens_input: assert property (@(posedge clk) disable iff (!rst_n)
        emit_go && row_reg == LAST_ROW |=> elements.ready)
        else $error("input closed after the final row result was registered");

    a_negative_flag_minimum: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> results.has_negative == results.row_minimum[ELEM_W-1])
        else $error("negative flag disagrees with the row minimum");

endmodule

[sim/matrix_row_sum_and_saddle_point_test.sv]
`timescale 1ns / 100ps
// Self-checking bench for the matrix row sum and saddle point search block.
// It loads matrices, ending on a partly loaded one, and checks every row result.
// Depends on mrs_pkg, the mrs_in_if and mrs_out_if interfaces and the block itself.
module matrix_row_sum_and_saddle_point_test;

    import mrs_pkg::*;

    localparam int CYCLE_LIMIT   = 100000;
    localparam int PARTIAL_ITEMS = 38;

    typedef struct {
        logic [ROW_W-1:0]         row_index;
        logic signed [SUM_W-1:0]  row_sum;
        logic                     has_negative;
        logic signed [ELEM_W-1:0] row_minimum;
        logic [COL_W-1:0]         minimum_column;
        logic                     is_saddle;
        logic                     last_row;
    } row_result_t;

    class row_summary_book;
        logic signed [ELEM_W-1:0] grid [CELLS];
        int                       fill = 0;
        row_result_t              awaited_rows [$];
        int                       mismatches = 0;

        function void take_element(input logic signed [ELEM_W-1:0] value);
            row_result_t              want;
            logic signed [ELEM_W-1:0] entry;
            logic signed [ELEM_W-1:0] low;
            int                       total;
            int                       low_col;
            bit                       negative;
            bit                       saddle;
            grid[fill] = value;
            fill++;
            if (fill < CELLS)
            begin
                return;
            end
            fill = 0;
            for (int row = 0; row < ROWS; row++)
            begin
                total    = 0;
                negative = 1'b0;
                low      = grid[row * COLS];
                low_col  = 0;
                for (int col = 0; col < COLS; col++)
                begin
                    entry = grid[row * COLS + col];
                    if (entry < 0)
                    begin
                        negative = 1'b1;
                    end
                    total += entry;
                    if (entry < low)
                    begin
                        low     = entry;
                        low_col = col;
                    end
                end
                saddle = 1'b1;
                for (int k = 0; k < ROWS; k++)
                begin
                    if (low < grid[k * COLS + low_col])
                    begin
                        saddle = 1'b0;
                    end
                end
                want.row_index      = ROW_W'(row);
                want.row_sum        = SUM_W'(total);
                want.has_negative   = negative;
                want.row_minimum    = low;
                want.minimum_column = COL_W'(low_col);
                want.is_saddle      = saddle;
                want.last_row       = (row == ROWS - 1);
                awaited_rows.push_back(want);
            end
        endfunction

        function void check_row(input row_result_t got);
            row_result_t want;
            if (awaited_rows.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("row result for row %0d arrived with none outstanding",
                             got.row_index);
                end
                return;
            end
            want = awaited_rows.pop_front();
            if (got.row_index !== want.row_index || got.row_sum !== want.row_sum
                || got.has_negative !== want.has_negative
                || got.row_minimum !== want.row_minimum
                || got.minimum_column !== want.minimum_column
                || got.is_saddle !== want.is_saddle || got.last_row !== want.last_row)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("expected row %0d sum %0d neg %0b min %0d col %0d saddle %0b last %0b",
                             want.row_index, want.row_sum, want.has_negative,
                             want.row_minimum, want.minimum_column, want.is_saddle,
                             want.last_row);
                    $display("     got row %0d sum %0d neg %0b min %0d col %0d saddle %0b last %0b",
                             got.row_index, got.row_sum, got.has_negative,
                             got.row_minimum, got.minimum_column, got.is_saddle,
                             got.last_row);
                end
            end
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    bit   steady = 1'b0;
    int   cycles = 0;

    row_summary_book book;
    row_result_t     seen;

    mrs_in_if  elements_ch ();
    mrs_out_if results_ch ();

    matrix_row_sum_and_saddle_point uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .elements(elements_ch),
        .results (results_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("matrix_row_sum_and_saddle_point: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && results_ch.valid && results_ch.ready)
        begin
            seen.row_index      = results_ch.row_index;
            seen.row_sum        = results_ch.row_sum;
            seen.has_negative   = results_ch.has_negative;
            seen.row_minimum    = results_ch.row_minimum;
            seen.minimum_column = results_ch.minimum_column;
            seen.is_saddle      = results_ch.is_saddle;
            seen.last_row       = results_ch.last_row;
            book.check_row(seen);
        end
        results_ch.ready <= steady || ($urandom_range(0, 99) >= 29);
    end

    task automatic send_element(input logic signed [ELEM_W-1:0] value);
        while (!steady && $urandom_range(0, 99) < 29)
        begin
            elements_ch.valid <= 1'b0;
            @(posedge clk);
        end
        elements_ch.valid   <= 1'b1;
        elements_ch.element <= value;
        @(posedge clk);
        while (!elements_ch.ready)
        begin
            @(posedge clk);
        end
        book.take_element(value);
    endtask

    initial
    begin
        logic signed [ELEM_W-1:0] value;
        book = new();
        elements_ch.valid   <= 1'b0;
        elements_ch.element <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int row = 0; row < ROWS; row++)
        begin
            for (int col = 0; col < COLS; col++)
            begin
                case (row)
                    0: value = 16'sh7FFF;
                    1: value = 16'sh8000;
                    2: value = ELEM_W'(col);
                    3: value = ELEM_W'(COLS - 1 - col);
                    4: value = (col == 5 || col == 6) ? -16'sd7 : ELEM_W'(col);
                    5: value = col[0] ? 16'sh8000 : 16'sh7FFF;
                    6: value = col[0] ? 16'shAAAA : 16'sh5555;
                    default: value = '0;
                endcase
                send_element(value);
            end
        end

        for (int m = 0; m < 3; m++)
        begin
            if (m == 1)
            begin
                elements_ch.valid <= 1'b0;
                while (book.awaited_rows.size() != 0)
                begin
                    @(posedge clk);
                end
            end
            steady = (m == 1);
            for (int i = 0; i < ((m == 2) ? PARTIAL_ITEMS : CELLS); i++)
            begin
                case (m)
                    0: value = ELEM_W'($urandom);
                    1:
                    begin
                        case ($urandom_range(0, 2))
                            0: value = ELEM_W'($urandom);
                            1: value = ELEM_W'(int'($urandom_range(0, 4)) - 2);
                            default: value = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                        endcase
                    end
                    default:
                        value = ELEM_W'((i % COLS) * 4 + int'($urandom_range(0, 3)) - 16);
                endcase
                send_element(value);
            end
        end
        steady = 1'b0;
        elements_ch.valid <= 1'b0;

        while (book.awaited_rows.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
        if (book.mismatches == 0)
        begin
            $display("matrix_row_sum_and_saddle_point: match");
        end
        else
        begin
            $display("matrix_row_sum_and_saddle_point: mismatch");
        end
        $finish;
    end

endmodule
